// ===== rtl/core/csvspi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvspi_pkg
// Shared types and constants of the CSV separator position indexer.
// ----------------------------------------------------------------------------
package csvspi_pkg;

    // Default sizes
    localparam int POSITION_BITS_DEFAULT    = 32;
    localparam int FIELD_COUNT_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT      = 4;

    // Fixed result field widths
    localparam int POS_OUT_BITS   = 32;
    localparam int ROW_BITS       = 32;
    localparam int FIELD_OUT_BITS = 16;
    localparam int SKIP_BITS      = 16;

    // Character codes
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_NUL = 8'd0;
    localparam logic [7:0] CH_COMMA = 8'd44;

    // Configuration register indexes
    localparam logic [1:0] CFG_SEPARATOR = 2'd0;
    localparam logic [1:0] CFG_COMMENT   = 2'd1;
    localparam logic [1:0] CFG_SKIP      = 2'd2;

    // Parser phase
    typedef enum logic [2:0] {
        PH_SKIP,
        PH_LINE_START,
        PH_COMMENT,
        PH_IN_ROW,
        PH_GAP,
        PH_DONE
    } phase_t;

    // Mark kinds
    typedef enum logic [1:0] {
        MARK_ROW_START,
        MARK_SEPARATOR,
        MARK_ROW_END
    } mark_kind_t;

    // Input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_t;

    // Output request
    typedef struct packed {
        logic [POS_OUT_BITS-1:0]   position;
        mark_kind_t                mark_kind;
        logic [ROW_BITS-1:0]       row_index;
        logic [FIELD_OUT_BITS-1:0] field_index;
        logic                      last_of_run;
    } out_t;

    // One mark as queued
    typedef struct packed {
        logic [POS_OUT_BITS-1:0]   position;
        mark_kind_t                mark_kind;
        logic [ROW_BITS-1:0]       row_index;
        logic [FIELD_OUT_BITS-1:0] field_index;
    } mark_t;

    // Queue entry: the marks caused by one input byte
    typedef struct packed {
        logic  two;
        mark_t m0;
        mark_t m1;
    } entry_t;

endpackage

// ===== rtl/core/csv_separator_position_indexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_separator_position_indexer
// Indexes row starts, separators and row ends of a CSV byte stream.
//
//   Port group   Dir  Handshake         Request
//   in_*         in   in_valid/in_stall  one byte or end of file
//   out_*        out  out_valid/out_stall one mark (row start/sep/row end)
//   cfg_*        in   cfg_write          register write, no read-back
//
// One byte is classified per cycle; a request is taken every cycle while the
// entry queue has room. Each byte yields up to two marks, sent one per cycle
// from the output register unless stalled, so mark-heavy input is limited by
// the output. Each mark is queued and then registered. Reset is asynchronous
// and needs no clearing pass. Either side may stall; the queue decouples them.
// ----------------------------------------------------------------------------
module csv_separator_position_indexer
    import csvspi_pkg::*;
#(
    parameter int POSITION_BITS    = POSITION_BITS_DEFAULT,
    parameter int FIELD_COUNT_BITS = FIELD_COUNT_BITS_DEFAULT,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic   q_push, q_pop, q_full, q_empty;
    entry_t q_entry, q_head;

    // Classifier
    csvspi_front #(
        .POSITION_BITS    (POSITION_BITS),
        .FIELD_COUNT_BITS (FIELD_COUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // Entry queue
    csvspi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // Mark output
    csvspi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/core/csvspi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvspi_front
// Classifies each byte, tracks phase and counters, and builds mark entries.
// ----------------------------------------------------------------------------
module csvspi_front
    import csvspi_pkg::*;
#(
    parameter int POSITION_BITS    = POSITION_BITS_DEFAULT,
    parameter int FIELD_COUNT_BITS = FIELD_COUNT_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        q_full,
    output logic        q_push,
    output entry_t      q_entry
);

    // Configuration and state registers
    logic [7:0]                  separator_reg;
    logic [7:0]                  comment_reg;
    logic [SKIP_BITS-1:0]        skip_lines_reg;
    phase_t                      phase_reg, phase_next;
    logic [POSITION_BITS-1:0]    byte_pos_reg, byte_pos_next;
    logic [SKIP_BITS-1:0]        skipped_reg, skipped_next;
    logic [ROW_BITS-1:0]         row_reg, row_next;
    logic [FIELD_COUNT_BITS-1:0] marks_reg, marks_next;

    logic                        accept;
    phase_t                      eff_phase;
    logic [7:0]                  b;
    logic                        eof;
    logic                        nl;
    logic                        is_sep;
    logic                        is_cmt;
    logic [SKIP_BITS-1:0]        skipped_inc;
    logic [1:0]                  n_marks;
    mark_kind_t                  kind0, kind1;
    logic [FIELD_COUNT_BITS-1:0] marks_p1, marks_p2;
    logic [POSITION_BITS+POS_OUT_BITS-1:0]     pos_ext;
    logic [FIELD_COUNT_BITS+FIELD_OUT_BITS-1:0] f0_ext, f1_ext;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign b        = in_data.data_byte;
    assign eof      = in_data.end_of_file;
    assign nl       = (b == CH_LF) || (b == CH_CR);
    assign is_sep   = (b == separator_reg);
    assign is_cmt   = (comment_reg != CH_NUL) && (b == comment_reg);
    assign skipped_inc = skipped_reg + SKIP_BITS'(1);

    // Header skipping ends as soon as the count is reached
    assign eff_phase = (phase_reg == PH_SKIP && skipped_reg >= skip_lines_reg)
                       ? PH_LINE_START : phase_reg;

    // Next phase
    always_comb
    begin
        phase_next   = eff_phase;
        skipped_next = skipped_reg;
        if (eof)
        begin
            phase_next = PH_DONE;
        end
        else
        begin
            unique case (eff_phase)
                PH_SKIP:
                begin
                    if (b == CH_LF)
                    begin
                        skipped_next = skipped_inc;
                        if (skipped_inc >= skip_lines_reg)
                            phase_next = PH_LINE_START;
                    end
                end
                PH_COMMENT:
                begin
                    if (b == CH_LF)
                        phase_next = PH_LINE_START;
                end
                PH_IN_ROW:
                begin
                    if (nl)
                        phase_next = PH_GAP;
                end
                PH_LINE_START, PH_GAP:
                begin
                    if (eff_phase == PH_LINE_START && is_cmt)
                        phase_next = (b == CH_LF) ? PH_LINE_START : PH_COMMENT;
                    else if (eff_phase == PH_GAP && nl)
                        phase_next = PH_GAP;
                    else
                        phase_next = nl ? PH_GAP : PH_IN_ROW;
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = eff_phase;
                end
            endcase
        end
    end

    // Marks caused by this byte
    always_comb
    begin
        n_marks = 2'd0;
        kind0   = MARK_ROW_START;
        kind1   = MARK_ROW_END;
        if (eof)
        begin
            if (eff_phase == PH_IN_ROW)
            begin
                n_marks = 2'd1;
                kind0   = MARK_ROW_END;
            end
        end
        else
        begin
            unique case (eff_phase)
                PH_IN_ROW:
                begin
                    if (nl)
                    begin
                        n_marks = 2'd1;
                        kind0   = MARK_ROW_END;
                    end
                    else if (is_sep)
                    begin
                        n_marks = 2'd1;
                        kind0   = MARK_SEPARATOR;
                    end
                end
                PH_LINE_START, PH_GAP:
                begin
                    if (!(eff_phase == PH_LINE_START && is_cmt) &&
                        !(eff_phase == PH_GAP && nl))
                    begin
                        kind0 = MARK_ROW_START;
                        if (nl)
                        begin
                            n_marks = 2'd2;
                            kind1   = MARK_ROW_END;
                        end
                        else if (is_sep)
                        begin
                            n_marks = 2'd2;
                            kind1   = MARK_SEPARATOR;
                        end
                        else
                        begin
                            n_marks = 2'd1;
                        end
                    end
                end
                PH_SKIP, PH_COMMENT, PH_DONE:
                begin
                    n_marks = 2'd0;
                end
                default:
                begin
                    n_marks = 2'd0;
                end
            endcase
        end
    end

    // Saturating mark counts
    assign marks_p1 = (&marks_reg) ? marks_reg : marks_reg + FIELD_COUNT_BITS'(1);
    assign marks_p2 = (&marks_p1) ? marks_p1 : marks_p1 + FIELD_COUNT_BITS'(1);

    // Counter updates
    always_comb
    begin
        byte_pos_next = byte_pos_reg;
        row_next      = row_reg;
        marks_next    = marks_reg;
        if (!eof && eff_phase != PH_DONE && !(&byte_pos_reg))
            byte_pos_next = byte_pos_reg + POSITION_BITS'(1);
        if ((n_marks == 2'd1 && kind0 == MARK_ROW_END) ||
            (n_marks == 2'd2 && kind1 == MARK_ROW_END))
        begin
            marks_next = '0;
            if (!(&row_reg))
                row_next = row_reg + ROW_BITS'(1);
        end
        else if (n_marks == 2'd1)
            marks_next = marks_p1;
        else if (n_marks == 2'd2)
            marks_next = marks_p2;
    end

    // Entry assembly
    assign pos_ext = {{POS_OUT_BITS{1'b0}}, byte_pos_reg};
    assign f0_ext  = {{FIELD_OUT_BITS{1'b0}}, marks_reg};
    assign f1_ext  = {{FIELD_OUT_BITS{1'b0}}, marks_p1};

    always_comb
    begin
        q_entry.two            = (n_marks == 2'd2);
        q_entry.m0.position    = pos_ext[POS_OUT_BITS-1:0];
        q_entry.m0.mark_kind   = kind0;
        q_entry.m0.row_index   = row_reg;
        q_entry.m0.field_index = f0_ext[FIELD_OUT_BITS-1:0];
        q_entry.m1.position    = pos_ext[POS_OUT_BITS-1:0];
        q_entry.m1.mark_kind   = kind1;
        q_entry.m1.row_index   = row_reg;
        q_entry.m1.field_index = f1_ext[FIELD_OUT_BITS-1:0];
    end

    assign q_push = accept && (n_marks != 2'd0);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg  <= CH_COMMA;
            comment_reg    <= CH_NUL;
            skip_lines_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SEPARATOR: separator_reg  <= cfg_data[7:0];
                CFG_COMMENT:   comment_reg    <= cfg_data[7:0];
                CFG_SKIP:      skip_lines_reg <= cfg_data[SKIP_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SKIP;
            byte_pos_reg <= '0;
            skipped_reg  <= '0;
            row_reg      <= '0;
            marks_reg    <= '0;
        end
        else if (accept && phase_reg != PH_DONE)
        begin
            phase_reg    <= phase_next;
            byte_pos_reg <= byte_pos_next;
            skipped_reg  <= skipped_next;
            row_reg      <= row_next;
            marks_reg    <= marks_next;
        end
    end

endmodule

// ===== rtl/core/csvspi_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvspi_queue
// Small FIFO of mark entries between the classifier and the output side.
// ----------------------------------------------------------------------------
module csvspi_queue
    import csvspi_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   full,
    output logic   empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

    entry_t                slots [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_BITS'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_BITS'(1);
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_BITS'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== rtl/core/csvspi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvspi_back
// Splits queued entries into single marks and drives the output register.
// ----------------------------------------------------------------------------
module csvspi_back
    import csvspi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  entry_t head,
    input  logic   empty,
    output logic   pop,
    output logic   out_valid,
    input  logic   out_stall,
    output out_t   out_data
);

    logic   out_valid_reg;
    out_t   out_data_reg, out_data_next;
    logic   sel_reg;
    logic   load;
    mark_t  cur;

    // Output register is free when empty or being taken
    assign load = !empty && (!out_valid_reg || !out_stall);
    assign pop  = load && (sel_reg || !head.two);
    assign cur  = sel_reg ? head.m1 : head.m0;

    always_comb
    begin
        out_data_next.position    = cur.position;
        out_data_next.mark_kind   = cur.mark_kind;
        out_data_next.row_index   = cur.row_index;
        out_data_next.field_index = cur.field_index;
        out_data_next.last_of_run = sel_reg || !head.two;
    end

    // Handshake and mark select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (load)
                sel_reg <= !pop;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== tb/sv/csv_separator_position_indexer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_separator_position_indexer_test
// Self-checking bench for the CSV separator position indexer.
//
// One file goes through the block after a single reset. The file has header
// lines, comment lines, directed corner rows and then random CSV rows under a
// series of separator settings, and it ends with end of file. A scoreboard
// class tracks the parser state, predicts the marks of every accepted request
// and checks each mark that leaves the block. Both sides idle at random, one
// section runs with no idling, and the receiver once holds off long enough
// to back the block up.
// ----------------------------------------------------------------------------
module csv_separator_position_indexer_test;
    import csvspi_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PERCENT = 12;

    // Tracks the parser and the marks still owed by the block
    class csv_mark_predictor;
        logic [7:0]  separator;
        logic [7:0]  comment_byte;
        int          skip_target;
        phase_t      parse_phase;
        logic [31:0] byte_pos;
        int          lines_skipped;
        logic [31:0] row_num;
        logic [15:0] marks_in_row;
        out_t        made [2];
        int          made_n;
        out_t        awaited_marks [$];
        int          requests_noted;
        int          marks_checked;
        int          mismatches;

        function new();
            separator      = CH_COMMA;
            comment_byte   = CH_NUL;
            skip_target    = 0;
            parse_phase    = PH_SKIP;
            byte_pos       = '0;
            lines_skipped  = 0;
            row_num        = '0;
            marks_in_row   = '0;
            made_n         = 0;
            requests_noted = 0;
            marks_checked  = 0;
            mismatches     = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_SEPARATOR: separator = value[7:0];
                CFG_COMMENT:   comment_byte = value[7:0];
                CFG_SKIP:      skip_target = int'(value);
                default:       ;
            endcase
        endfunction

        // One mark at the current position; counters saturate
        function void add_mark(mark_kind_t kind);
            made[made_n].position    = byte_pos;
            made[made_n].mark_kind   = kind;
            made[made_n].row_index   = row_num;
            made[made_n].field_index = marks_in_row;
            made[made_n].last_of_run = 1'b0;
            made_n++;
            if (marks_in_row != '1)
                marks_in_row++;
            if (kind == MARK_ROW_END)
            begin
                if (row_num != '1)
                    row_num++;
                marks_in_row = '0;
            end
        endfunction

        // Accepted request: advance the parser and queue its marks
        function void note_request(in_t req);
            logic [7:0] b;
            logic       nl;
            b = req.data_byte;
            nl = (b == CH_LF) || (b == CH_CR);
            made_n = 0;
            requests_noted++;
            if (parse_phase == PH_DONE)
                return;
            if (parse_phase == PH_SKIP && lines_skipped >= skip_target)
                parse_phase = PH_LINE_START;

            if (req.end_of_file)
            begin
                if (parse_phase == PH_IN_ROW)
                    add_mark(MARK_ROW_END);
                parse_phase = PH_DONE;
            end
            else
            begin
                case (parse_phase)
                    PH_SKIP:
                    begin
                        if (b == CH_LF)
                        begin
                            lines_skipped++;
                            if (lines_skipped >= skip_target)
                                parse_phase = PH_LINE_START;
                        end
                    end
                    PH_COMMENT:
                    begin
                        if (b == CH_LF)
                            parse_phase = PH_LINE_START;
                    end
                    PH_IN_ROW:
                    begin
                        if (nl)
                        begin
                            add_mark(MARK_ROW_END);
                            parse_phase = PH_GAP;
                        end
                        else if (b == separator)
                            add_mark(MARK_SEPARATOR);
                    end
                    default:
                    begin
                        // line start or gap between rows
                        if (parse_phase == PH_LINE_START && comment_byte != CH_NUL
                            && b == comment_byte)
                            parse_phase = (b == CH_LF) ? PH_LINE_START : PH_COMMENT;
                        else if (!(parse_phase == PH_GAP && nl))
                        begin
                            add_mark(MARK_ROW_START);
                            if (nl)
                            begin
                                add_mark(MARK_ROW_END);
                                parse_phase = PH_GAP;
                            end
                            else
                            begin
                                if (b == separator)
                                    add_mark(MARK_SEPARATOR);
                                parse_phase = PH_IN_ROW;
                            end
                        end
                    end
                endcase
                if (byte_pos != '1)
                    byte_pos++;
            end

            if (made_n > 0)
                made[made_n - 1].last_of_run = 1'b1;
            for (int i = 0; i < made_n; i++)
                awaited_marks = {awaited_marks, made[i]};
        endfunction

        // Accepted mark: compare against the oldest one awaited
        function void check_mark(out_t got);
            out_t want;
            logic bad;
            marks_checked++;
            if (awaited_marks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR %0t: unexpected mark pos=%0d kind=%0d row=%0d field=%0d last=%0b",
                             $time, got.position, got.mark_kind, got.row_index,
                             got.field_index, got.last_of_run);
                return;
            end
            want = awaited_marks.pop_front();
            bad = (got.position !== want.position) || (got.mark_kind !== want.mark_kind)
                  || (got.row_index !== want.row_index)
                  || (got.field_index !== want.field_index)
                  || (got.last_of_run !== want.last_of_run);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR %0t: mark mismatch", $time);
                    $display("  expected pos=%0d kind=%0d row=%0d field=%0d last=%0b",
                             want.position, want.mark_kind, want.row_index,
                             want.field_index, want.last_of_run);
                    $display("  actual   pos=%0d kind=%0d row=%0d field=%0d last=%0b",
                             got.position, got.mark_kind, got.row_index,
                             got.field_index, got.last_of_run);
                end
            end
        endfunction

        function int pending();
            return awaited_marks.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_t         in_data;
    logic        out_valid;
    logic        out_stall;
    out_t        out_data;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    csv_mark_predictor mark_predictor = new();

    bit         no_idle = 1'b0;
    bit         hold_output = 1'b0;
    logic [7:0] sep_now = CH_COMMA;
    int         sep_settings = 0;
    int         cycle_count = 0;

    csv_separator_position_indexer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("csv_separator_position_indexer verification failed");
            $finish;
        end
    end

    // Both handshakes are observed at the edge where they complete
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                mark_predictor.note_request(in_data);
            if (out_valid && !out_stall)
                mark_predictor.check_mark(out_data);
        end
    end

    // Receiver: random stalls, or a long hold when asked
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_output && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_output = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (no_idle)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Offer one request and return at the edge that takes it
    task automatic send_request(input logic [7:0] b, input logic eof);
        in_t req;
        req.data_byte = b;
        req.end_of_file = eof;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_request(s[i], 1'b0);
    endtask

    // Let every owed mark drain, then give the pipeline time to settle
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mark_predictor.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        mark_predictor.set_register(idx, value);
        if (idx == CFG_SEPARATOR)
        begin
            sep_now = value[7:0];
            sep_settings++;
        end
        @(posedge clk);
    endtask

    // Field content: mostly printable text, some raw bytes as noise
    function automatic logic [7:0] field_byte();
        if ($urandom_range(0, 99) < 80)
            return 8'($urandom_range(32, 126));
        return 8'($urandom_range(0, 255));
    endfunction

    // Random rows until about budget bytes have gone out
    task automatic send_random_rows(input int budget);
        int sent;
        int fields;
        int len;
        int pick;
        sent = 0;
        while (sent < budget)
        begin
            fields = $urandom_range(1, 5);
            for (int f = 0; f < fields; f++)
            begin
                if (f > 0)
                begin
                    send_request(sep_now, 1'b0);
                    sent++;
                end
                len = $urandom_range(0, 6);
                repeat (len)
                begin
                    send_request(field_byte(), 1'b0);
                    sent++;
                end
            end
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                send_text("\n");
                sent += 1;
            end
            else if (pick < 7)
            begin
                send_text("\r\n");
                sent += 2;
            end
            else if (pick < 8)
            begin
                send_text("\r");
                sent += 1;
            end
            else if (pick < 9)
            begin
                send_text("\n\n\r");
                sent += 3;
            end
        end
    endtask

    function automatic logic [7:0] separator_for(input int n);
        case (n)
            0: return 8'h3B;            // ';'
            1: return 8'h09;            // tab
            2: return 8'h7C;            // '|'
            3: return CH_NUL;
            4: return 8'hFF;
            5: return CH_CR;
            6: return CH_LF;
            7: return CH_COMMA;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin : stimulus
        int failed;
        rst_n     = 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_SEPARATOR;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header lines under the widest skip count; CR does not count
        write_register(CFG_SKIP, 16'hFFFF);
        write_register(CFG_COMMENT, 16'h0023);
        send_text("a");
        send_request(8'hFF, 1'b0);
        send_text("\r\n");
        send_request(8'h00, 1'b0);
        send_text("\n");

        // Lowering the skip count below the lines seen ends skipping
        wait_drain();
        write_register(CFG_SKIP, 16'd1);
        send_text("#x\n");

        wait_drain();
        write_register(CFG_COMMENT, 16'h00FF);
        send_request(8'hFF, 1'b0);
        send_text("\n");

        // Comment char LF: a bare LF line is a comment
        wait_drain();
        write_register(CFG_COMMENT, {8'h00, CH_LF});
        send_text("\n");

        // First data byte is CR: empty row; then a row opening on a separator
        wait_drain();
        write_register(CFG_COMMENT, {8'h00, CH_NUL});
        send_text("\r,a,\n\r");

        // Separator equal to LF: LF still ends the row
        wait_drain();
        write_register(CFG_SEPARATOR, {8'h00, CH_LF});
        send_text("b\n");

        wait_drain();
        write_register(CFG_SEPARATOR, {8'h00, CH_NUL});
        send_request(CH_NUL, 1'b0);
        send_text("c\n");

        // Random sections, one separator setting each
        for (int phase_n = 0; phase_n < 9; phase_n++)
        begin
            wait_drain();
            write_register(CFG_SEPARATOR, {8'h00, separator_for(phase_n)});
            write_register(CFG_COMMENT, 16'($urandom_range(0, 255)));
            write_register(CFG_SKIP, (phase_n % 2 == 0) ? 16'd0 : 16'($urandom));
            no_idle = (phase_n == 2);
            if (phase_n == 4)
                hold_output = 1'b1;
            send_random_rows(42);
        end
        no_idle = 1'b0;

        // End of file inside a row or between rows, then ignored input
        if ($urandom_range(0, 1))
            send_text("z");
        else
            send_text("\n");
        send_request(8'($urandom), 1'b1);
        repeat (3)
            send_request(8'($urandom), 1'b0);
        send_request(8'($urandom), 1'b1);

        wait_drain();
        repeat (20) @(posedge clk);

        failed = mark_predictor.mismatches + mark_predictor.pending();
        if (mark_predictor.pending() != 0)
            $display("ERROR: %0d marks never arrived", mark_predictor.pending());
        $display("Fed %0d requests, checked %0d marks over %0d data rows, %0d separator settings",
                 mark_predictor.requests_noted, mark_predictor.marks_checked,
                 mark_predictor.row_num, sep_settings);
        $display("Covered header and comment skipping, CR/LF runs, end of file, %0d mismatches",
                 mark_predictor.mismatches);
        if (failed == 0)
            $display("csv_separator_position_indexer verification clean");
        else
            $display("csv_separator_position_indexer verification failed");
        $finish;
    end

endmodule
